// File: design/fswa_pkg.sv
// Package for the frame sliding window accumulator: sizes, mode codes,
// register indexes and the request struct passed from control to update.
// No dependencies.
`timescale 1ns / 1ps

package fswa_pkg;

	localparam int MAX_WINDOW   = 16;
	localparam int FRAME_PIXELS = 65536;
	localparam int PIXEL_BITS   = 16;

	localparam int PIX_W     = PIXEL_BITS;
	localparam int IN_PIX_W  = 16;
	localparam int SUM_W     = 32;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int HELD_W    = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W    = $clog2(MAX_WINDOW);
	localparam int POS_W     = $clog2(FRAME_PIXELS);
	localparam int HIST_AW   = SLOT_W + POS_W;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_ALL = 1'b1;

	localparam logic [1:0] MODE_PASS  = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_ACCUM = 2'd2;
	localparam logic [1:0] MODE_SLIDE = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic               full;
		logic [PIX_W-1:0]   pix;
		logic               last;
		logic [POS_W-1:0]   pos;
		logic [HIST_AW-1:0] hist_addr;
	} fswa_req_t;

endpackage

// File: design/fswa_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module fswa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/fswa_ctrl.sv
// Configuration registers, frame bookkeeping and per-beat request generation.
// Depends on fswa_pkg.
`timescale 1ns / 1ps

module fswa_ctrl (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [fswa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fswa_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  accept,
	input  logic [fswa_pkg::IN_PIX_W-1:0]         pixel_value,
	input  logic                                  frame_end,
	output fswa_pkg::fswa_req_t                   req
);
	import fswa_pkg::*;

	logic [CFG_W-1:0]  window_len_q;
	logic              accumulate_all_q;
	logic [HELD_W-1:0] frames_held_q;
	logic [SLOT_W-1:0] oldest_slot_q;
	logic [POS_W-1:0]  pixel_position_q;

	logic [HELD_W-1:0] win_eff;
	logic              full;
	logic [HELD_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot;
	logic [HELD_W-1:0] oldest_inc;
	logic [1:0]        mode;
	logic [31:0]       pix_ext;

	always_comb begin
		if (window_len_q == '0) begin
			win_eff = HELD_W'(1);
		end else if (32'(window_len_q) > MAX_WINDOW) begin
			win_eff = HELD_W'(MAX_WINDOW);
		end else begin
			win_eff = HELD_W'(window_len_q);
		end
	end

	assign full       = frames_held_q >= win_eff;
	assign slot_sum   = (HELD_W + 1)'(oldest_slot_q) + (HELD_W + 1)'(frames_held_q);
	assign oldest_inc = HELD_W'(oldest_slot_q) + HELD_W'(1);
	assign pix_ext    = 32'(pixel_value);

	always_comb begin
		if (full) begin
			slot = oldest_slot_q;
		end else if (slot_sum >= (HELD_W + 1)'(win_eff)) begin
			slot = SLOT_W'(slot_sum - (HELD_W + 1)'(win_eff));
		end else begin
			slot = SLOT_W'(slot_sum);
		end
	end

	always_comb begin
		if (win_eff == HELD_W'(1)) begin
			mode = MODE_PASS;
		end else if (frames_held_q == '0) begin
			mode = MODE_FIRST;
		end else if (accumulate_all_q) begin
			mode = MODE_ACCUM;
		end else begin
			mode = MODE_SLIDE;
		end
	end

	always_comb begin
		req.mode = mode;
		req.full = full;
		req.pix  = pix_ext[PIX_W-1:0];
		req.last = frame_end;
		req.pos  = pixel_position_q;
		if (mode == MODE_FIRST) begin
			req.hist_addr = {SLOT_W'(0), pixel_position_q};
		end else begin
			req.hist_addr = {slot, pixel_position_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q     <= CFG_W'(1);
			accumulate_all_q <= 1'b0;
			frames_held_q    <= '0;
			oldest_slot_q    <= '0;
			pixel_position_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_WINDOW_LEN: begin
					window_len_q <= cfg_data;
				end
				CFG_ACCUMULATE_ALL: begin
					accumulate_all_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
			frames_held_q    <= '0;
			oldest_slot_q    <= '0;
			pixel_position_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				pixel_position_q <= '0;
				if (mode == MODE_FIRST) begin
					frames_held_q <= HELD_W'(1);
				end else if (mode == MODE_SLIDE) begin
					if (full) begin
						oldest_slot_q <= (oldest_inc >= win_eff) ? '0 : SLOT_W'(oldest_inc);
					end else begin
						frames_held_q <= frames_held_q + HELD_W'(1);
					end
				end
			end else if (pixel_position_q == POS_W'(FRAME_PIXELS - 1)) begin
				pixel_position_q <= '0;
			end else begin
				pixel_position_q <= pixel_position_q + POS_W'(1);
			end
		end
	end

endmodule

// File: design/fswa_update.sv
// Read-modify-write of the running sum and history memories, with one-deep
// write forwarding and the output register. Depends on fswa_pkg and fswa_ram.
`timescale 1ns / 1ps

module fswa_update (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  fswa_pkg::fswa_req_t            req,
	output logic                           ready,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fswa_pkg::SUM_W-1:0]     sum_value,
	output logic                           frame_last,
	output logic                           saturated
);
	import fswa_pkg::*;

	fswa_req_t          req_s1;
	logic               valid_s1;
	logic               advance;

	logic [SUM_W-1:0]   sum_ram_rd;
	logic [PIX_W-1:0]   hist_ram_rd;
	logic [SUM_W-1:0]   sum_rd;
	logic [PIX_W-1:0]   hist_rd;

	logic               fw_sum_valid_q;
	logic [POS_W-1:0]   fw_sum_addr_q;
	logic [SUM_W-1:0]   fw_sum_data_q;
	logic               fw_hist_valid_q;
	logic [HIST_AW-1:0] fw_hist_addr_q;
	logic [PIX_W-1:0]   fw_hist_data_q;

	logic [SUM_W:0]     acc_wide;
	logic [SUM_W-1:0]   sum_new;
	logic               sat_new;
	logic               sum_we;
	logic               hist_we;

	logic               out_valid_q;
	logic [SUM_W-1:0]   sum_q;
	logic               last_q;
	logic               sat_q;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign ready   = !valid_s1 || advance;

	fswa_ram #(
		.WIDTH(SUM_W),
		.DEPTH(2 ** POS_W)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(req_s1.pos),
		.wdata(sum_new),
		.re   (accept),
		.raddr(req.pos),
		.rdata(sum_ram_rd)
	);

	fswa_ram #(
		.WIDTH(PIX_W),
		.DEPTH(2 ** HIST_AW)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(req_s1.hist_addr),
		.wdata(req_s1.pix),
		.re   (accept),
		.raddr(req.hist_addr),
		.rdata(hist_ram_rd)
	);

	assign sum_rd  = (fw_sum_valid_q && fw_sum_addr_q == req_s1.pos) ?
		fw_sum_data_q : sum_ram_rd;
	assign hist_rd = (fw_hist_valid_q && fw_hist_addr_q == req_s1.hist_addr) ?
		fw_hist_data_q : hist_ram_rd;

	assign acc_wide = (SUM_W + 1)'(sum_rd) + (SUM_W + 1)'(req_s1.pix);

	always_comb begin
		sat_new = 1'b0;
		case (req_s1.mode)
			MODE_ACCUM: begin
				if (acc_wide >= (SUM_W + 1)'(SUM_MAX)) begin
					sum_new = SUM_MAX;
					sat_new = 1'b1;
				end else begin
					sum_new = acc_wide[SUM_W-1:0];
				end
			end
			MODE_SLIDE: begin
				if (req_s1.full) begin
					sum_new = acc_wide[SUM_W-1:0] - SUM_W'(hist_rd);
				end else begin
					sum_new = acc_wide[SUM_W-1:0];
				end
			end
			default: begin
				sum_new = SUM_W'(req_s1.pix);
			end
		endcase
	end

	assign sum_we  = advance && (req_s1.mode != MODE_PASS);
	assign hist_we = advance && (req_s1.mode == MODE_FIRST || req_s1.mode == MODE_SLIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			fw_sum_valid_q  <= 1'b0;
			fw_hist_valid_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (sum_we) begin
				fw_sum_valid_q <= 1'b1;
			end
			if (hist_we) begin
				fw_hist_valid_q <= 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (sum_we) begin
			fw_sum_addr_q <= req_s1.pos;
			fw_sum_data_q <= sum_new;
		end
		if (hist_we) begin
			fw_hist_addr_q <= req_s1.hist_addr;
			fw_hist_data_q <= req_s1.pix;
		end
		if (advance) begin
			sum_q  <= sum_new;
			last_q <= req_s1.last;
			sat_q  <= sat_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign sum_value  = sum_q;
	assign frame_last = last_q;
	assign saturated  = sat_q;

endmodule

// File: design/frame_sliding_window_accumulator_unit.sv
// Frame sliding window accumulator, top level. Depends on fswa_pkg, fswa_ctrl, fswa_update.
// An accepted input beat is registered in the update stage (req_s1), then its sum in the output register.
// Throughput is one beat per cycle unless a full output register is held by out_stall.
// Reset clears the control state and sets a window of one; memory contents are not cleared.
`timescale 1ns / 1ps

module frame_sliding_window_accumulator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [fswa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fswa_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [fswa_pkg::IN_PIX_W-1:0]         pixel_value,
	input  logic                                  frame_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [fswa_pkg::SUM_W-1:0]            sum_value,
	output logic                                  frame_last,
	output logic                                  saturated
);
	import fswa_pkg::*;

	fswa_req_t req;
	logic      ready;
	logic      accept;

	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	fswa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pixel_value(pixel_value),
		.frame_end  (frame_end),
		.req        (req)
	);

	fswa_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum_value (sum_value),
		.frame_last(frame_last),
		.saturated (saturated)
	);

`ifndef SYNTHESIS
	// An empty output register must never hold back the input side.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register is empty");

	// A saturated beat always carries the full-scale sum.
	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (sum_value == SUM_MAX))
		else $error("saturated flag without full-scale sum");
`endif

endmodule
